// ----- rtl/tce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants for the tiny CPU execute core: instruction
// field layout, opcodes, decoded operation kinds and the decoded micro-op.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int DATA_W    = 8;
    localparam int PC_W      = 16;
    localparam int INSTR_W   = 16;
    localparam int OPC_W     = 5;
    localparam int QUEUE_DEPTH = 2;

    // Opcodes, instruction bits [15:11]
    localparam logic [OPC_W-1:0] OPC_ADD   = 5'b00000;
    localparam logic [OPC_W-1:0] OPC_SUB   = 5'b00001;
    localparam logic [OPC_W-1:0] OPC_HALT  = 5'b00010;
    localparam logic [OPC_W-1:0] OPC_MOV   = 5'b00011;
    localparam logic [OPC_W-1:0] OPC_LOADI = 5'b01000;

    // Decoded operation kinds (unknown opcodes fold into KIND_HALT)
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_HALT  = 3'd0;
    localparam t_kind KIND_MOV   = 3'd1;
    localparam t_kind KIND_LOADI = 3'd2;
    localparam t_kind KIND_ADD   = 3'd3;
    localparam t_kind KIND_SUB   = 3'd4;

    localparam logic [PC_W-1:0] PC_STEP = 16'd2;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    typedef logic [DATA_W-1:0]    t_data;

    // Decoded instruction as it travels from front to back
    typedef struct packed {
        t_kind    kind;
        t_reg_idx rd;
        t_reg_idx rs1;
        t_reg_idx rs2;
        t_data    imm;
        t_reg_idx peek;
    } t_uop;

    // Queue status seen by the front end and the back end
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

endpackage

// ----- rtl/tiny_cpu_execute_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_cpu_execute_core
// Executes one 16-bit instruction per transaction on eight 8-bit registers,
// ZNCV flags, a 16-bit pc and a halt flag. Front end decodes, a two-entry
// queue decouples it from the back end that reads registers and executes.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+--------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_instr_word, i_peek_index
//  output   | o_out_valid  | i_out_stall  | o_next_pc, o_wr_*, o_*_flag,
//           |              |              | o_is_halted, o_peek_value
//
//  One instruction per clock sustained while the output is not stalled; the
//  result passes the queue entry, the register read and the output register.
//  The register read stage with its write-through ports sets the latency.
//  Reset (i_rst_n low, synchronous) clears registers, flags, pc and halt.
//  A stalled output fills the back end and then the queue; o_in_stall rises
//  only when the queue is full.
// ----------------------------------------------------------------------------
module tiny_cpu_execute_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_instr_word,
    input  logic [2:0]  i_peek_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_next_pc,
    output logic        o_wr_valid,
    output logic [2:0]  o_wr_index,
    output logic [7:0]  o_wr_value,
    output logic        o_zero_flag,
    output logic        o_neg_flag,
    output logic        o_carry_flag,
    output logic        o_ovf_flag,
    output logic        o_is_halted,
    output logic [7:0]  o_peek_value
);
    import tce_pkg::*;

    t_q_stat q_stat;
    t_uop    push_uop;
    t_uop    head_uop;
    logic    push;
    logic    pop;

    tce_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_instr_word (i_instr_word),
        .i_peek_index (i_peek_index),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_uop        (push_uop)
    );

    tce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_uop   (push_uop),
        .i_pop   (pop),
        .o_uop   (head_uop),
        .o_stat  (q_stat)
    );

    tce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_uop        (head_uop),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_next_pc    (o_next_pc),
        .o_wr_valid   (o_wr_valid),
        .o_wr_index   (o_wr_index),
        .o_wr_value   (o_wr_value),
        .o_zero_flag  (o_zero_flag),
        .o_neg_flag   (o_neg_flag),
        .o_carry_flag (o_carry_flag),
        .o_ovf_flag   (o_ovf_flag),
        .o_is_halted  (o_is_halted),
        .o_peek_value (o_peek_value)
    );

endmodule

// ----- rtl/tce_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_front
// Front end: accepts instruction transactions, splits the instruction word
// into its fields and classifies the opcode into an operation kind.
// ----------------------------------------------------------------------------
module tce_front (
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [15:0]               i_instr_word,
    input  logic [2:0]                i_peek_index,
    input  tce_pkg::t_q_stat          i_q_stat,
    output logic                      o_push,
    output tce_pkg::t_uop             o_uop
);
    import tce_pkg::*;

    logic [OPC_W-1:0] opc;
    t_kind            kind;

    // Opcode classification
    assign opc = i_instr_word[15:11];

    always_comb begin
        case (opc)
            OPC_ADD:   kind = KIND_ADD;
            OPC_SUB:   kind = KIND_SUB;
            OPC_MOV:   kind = KIND_MOV;
            OPC_LOADI: kind = KIND_LOADI;
            default:   kind = KIND_HALT;  // HALT and undefined opcodes
        endcase
    end

    // Operand fields: kind, rd, rs1, rs2, imm, peek
    assign o_uop = {kind, i_instr_word[10:8], i_instr_word[7:5], i_instr_word[4:2],
                    i_instr_word[7:0], i_peek_index};

    // Handshake: hold off only while the queue is full
    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

endmodule

// ----- rtl/tce_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_queue
// Short decoupling queue of decoded micro-ops between front and back end.
// ----------------------------------------------------------------------------
module tce_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tce_pkg::t_uop    i_uop,
    input  logic             i_pop,
    output tce_pkg::t_uop    o_uop,
    output tce_pkg::t_q_stat o_stat
);
    import tce_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_uop             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_uop;
        end
    end

    assign o_uop            = r_slot[r_rd_ptr];
    assign o_stat.full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.not_empty = (r_count != '0);

    // Occupancy never goes past the depth or below empty
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_W'(QUEUE_DEPTH)))
        else $error("push into full queue");

endmodule

// ----- rtl/tce_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_back
// Back end: register read stage (write-through register file), then
// execute into the output register. Holds registers, flags, pc and halt.
// ----------------------------------------------------------------------------
module tce_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tce_pkg::t_q_stat         i_q_stat,
    input  tce_pkg::t_uop            i_uop,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [15:0]              o_next_pc,
    output logic                     o_wr_valid,
    output logic [2:0]               o_wr_index,
    output logic [7:0]               o_wr_value,
    output logic                     o_zero_flag,
    output logic                     o_neg_flag,
    output logic                     o_carry_flag,
    output logic                     o_ovf_flag,
    output logic                     o_is_halted,
    output logic [7:0]               o_peek_value
);
    import tce_pkg::*;

    // Register file: two copies, one for the source ports, one for peek
    t_data    mem_src  [REG_COUNT];
    t_data    mem_peek [REG_COUNT];
    logic [REG_COUNT-1:0] r_reg_vld;

    // Read stage
    logic     r_rd_valid;
    t_uop     r_uop;
    t_data    r_src_a;
    t_data    r_src_b;
    t_data    r_peek_data;

    // Architectural state
    logic [PC_W-1:0] r_pc, n_pc;
    logic [3:0]      r_flags, n_flags;   // Z N C V
    logic            r_halt, n_halt;

    // Output register
    logic            r_out_valid;
    logic [PC_W-1:0] r_out_pc;
    logic            r_out_wr_valid;
    t_reg_idx        r_out_wr_index;
    t_data           r_out_wr_value;
    logic [3:0]      r_out_flags;
    logic            r_out_halt;
    t_data           r_out_peek;

    logic     out_free;
    logic     adv_x;
    logic     load_r;
    logic     wen;
    t_data    wdata;
    t_data    opnd_b;
    logic [DATA_W:0] sum;
    t_data    peek_val;

    // Pipeline advance
    assign out_free = !r_out_valid || !i_out_stall;
    assign adv_x    = r_rd_valid && out_free;
    assign load_r   = i_q_stat.not_empty && (!r_rd_valid || adv_x);
    assign o_pop    = load_r;

    // Adder: SUB adds the two's complement of the second source
    assign opnd_b = (r_uop.kind == KIND_SUB) ? t_data'(~r_src_b + 1'b1) : r_src_b;
    assign sum    = {1'b0, r_src_a} + {1'b0, opnd_b};

    // Execute
    always_comb begin
        wen     = 1'b0;
        wdata   = '0;
        n_flags = r_flags;
        n_halt  = r_halt;
        case (r_uop.kind)
            KIND_MOV: begin
                wen   = 1'b1;
                wdata = r_src_a;
            end
            KIND_LOADI: begin
                wen   = 1'b1;
                wdata = r_uop.imm;
            end
            KIND_ADD, KIND_SUB: begin
                wen        = 1'b1;
                wdata      = sum[DATA_W-1:0];
                n_flags[3] = (sum[DATA_W-1:0] == '0);
                n_flags[2] = sum[DATA_W-1];
                n_flags[1] = sum[DATA_W];
                n_flags[0] = (r_src_a[DATA_W-1] == opnd_b[DATA_W-1]) &&
                             (sum[DATA_W-1] != r_src_a[DATA_W-1]);
            end
            default: begin
                n_halt = 1'b1;
            end
        endcase
        n_pc = r_pc + PC_STEP;
    end

    // Peek sees this instruction's own write
    assign peek_val = (wen && r_uop.rd == r_uop.peek) ? wdata : r_peek_data;

    // Register file write
    always_ff @(posedge i_clk) begin
        if (adv_x && wen) begin
            mem_src[r_uop.rd]  <= wdata;
            mem_peek[r_uop.rd] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld <= '0;
        end else if (adv_x && wen) begin
            r_reg_vld[r_uop.rd] <= 1'b1;
        end
    end

    // Register file read, write-through for the instruction executing now
    always_ff @(posedge i_clk) begin
        if (load_r) begin
            r_uop <= i_uop;
            if (adv_x && wen && r_uop.rd == i_uop.rs1) begin
                r_src_a <= wdata;
            end else begin
                r_src_a <= r_reg_vld[i_uop.rs1] ? mem_src[i_uop.rs1] : '0;
            end
            if (adv_x && wen && r_uop.rd == i_uop.rs2) begin
                r_src_b <= wdata;
            end else begin
                r_src_b <= r_reg_vld[i_uop.rs2] ? mem_src[i_uop.rs2] : '0;
            end
            if (adv_x && wen && r_uop.rd == i_uop.peek) begin
                r_peek_data <= wdata;
            end else begin
                r_peek_data <= r_reg_vld[i_uop.peek] ? mem_peek[i_uop.peek] : '0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_flags     <= '0;
            r_halt      <= 1'b0;
        end else begin
            if (load_r) begin
                r_rd_valid <= 1'b1;
            end else if (adv_x) begin
                r_rd_valid <= 1'b0;
            end
            if (adv_x) begin
                r_out_valid <= 1'b1;
                r_pc        <= n_pc;
                r_flags     <= n_flags;
                r_halt      <= n_halt;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (adv_x) begin
            r_out_pc       <= n_pc;
            r_out_wr_valid <= wen;
            r_out_wr_index <= wen ? r_uop.rd : '0;
            r_out_wr_value <= wdata;
            r_out_flags    <= n_flags;
            r_out_halt     <= n_halt;
            r_out_peek     <= peek_val;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_next_pc    = r_out_pc;
    assign o_wr_valid   = r_out_wr_valid;
    assign o_wr_index   = r_out_wr_index;
    assign o_wr_value   = r_out_wr_value;
    assign o_zero_flag  = r_out_flags[3];
    assign o_neg_flag   = r_out_flags[2];
    assign o_carry_flag = r_out_flags[1];
    assign o_ovf_flag   = r_out_flags[0];
    assign o_is_halted  = r_out_halt;
    assign o_peek_value = r_out_peek;

    // pc steps by two per executed instruction
    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_x |=> (r_pc == $past(r_pc) + PC_STEP))
        else $error("pc did not advance by two");

    // halt is sticky
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");

    // no write reported means zeroed index and value
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_wr_valid) |-> (r_out_wr_index == '0 && r_out_wr_value == '0))
        else $error("stray write fields");

    // a waiting read-stage transaction is not lost
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid && !adv_x) |=> r_rd_valid)
        else $error("read stage transaction dropped");

endmodule
